/* rtl/core/itp_pkg.sv */
// Shared types and constants for the ISO timestamp text parser.
// Used by itp_ctrl, itp_dpath and iso_timestamp_text_parser; no dependencies.
package itp_pkg;

  // Parse phase of the string.
  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_FRAC   = 2'd1,
    PH_ZONE   = 2'd2
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;   // take the presented character
    logic clear;  // return the parse state to its reset value
    logic load;   // copy the finished result into the output register
  } cmd_t;

  // Cycles that the arithmetic pipeline needs after the final character.
  localparam int unsigned CalcCycles = 8;
  localparam int unsigned CalcCntW   = $clog2(CalcCycles);

  // Shape of the date and time fields: 1 where a digit is required.
  localparam logic [0:9] DateShape = 10'b1111011011;
  localparam logic [0:8] TimeShape = 9'b011011011;

  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrDot   = 8'h2e;
  localparam logic [7:0] ChrPlus  = 8'h2b;
  localparam logic [7:0] ChrMinus = 8'h2d;
  localparam logic [7:0] ChrColon = 8'h3a;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0d;
  localparam logic [7:0] ChrNul   = 8'h00;

  // Scale of the kept fraction digits to microseconds.
  function automatic logic [16:0] frac_scale(input logic [2:0] count);
    logic [16:0] s;
    unique case (count)
      3'd1:    s = 17'd100000;
      3'd2:    s = 17'd10000;
      3'd3:    s = 17'd1000;
      3'd4:    s = 17'd100;
      3'd5:    s = 17'd10;
      3'd6:    s = 17'd1;
      default: s = 17'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/itp_ctrl.sv */
// Controller of the ISO timestamp text parser: sequences character intake,
// the arithmetic wait and the output register. Depends on itp_pkg.
module itp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_char_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output itp_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [itp_pkg::CalcCntW-1:0]    cnt_q;
  logic                            out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.step  = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load  = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
    cmd_o.clear = cmd_o.load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && last_char_i) begin
            state_q <= ST_CALC;
            cnt_q   <= '0;
          end
        end
        ST_CALC: begin
          if (cnt_q == itp_pkg::CalcCntW'(itp_pkg::CalcCycles - 1)) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (cmd_o.load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/itp_dpath.sv */
// Datapath of the ISO timestamp text parser: field accumulators, zone
// scanners, the epoch arithmetic pipeline and the result register.
// Depends on itp_pkg.
module itp_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itp_pkg::cmd_t cmd_i,
  input  logic [7:0]    character_i,
  output logic          valid_res_o,
  output logic [58:0]   epoch_micros_o
);

  typedef enum logic [1:0] {
    SC_LEAD,
    SC_NUM,
    SC_STOP
  } scan_e;

  typedef struct packed {
    scan_e      st;
    logic [6:0] acc;
    logic       neg;
  } scan_t;

  function automatic scan_t scan_num(input scan_t s, input logic [7:0] c);
    scan_t      r;
    logic       dig;
    logic [9:0] v;
    r   = s;
    dig = (c >= itp_pkg::ChrZero) && (c <= itp_pkg::ChrNine);
    v   = 10'(s.acc) * 10'd10 + 10'(c[3:0]);
    if (v > 10'd99) begin
      v = 10'd99;
    end
    unique case (s.st)
      SC_LEAD: begin
        if (c == itp_pkg::ChrSpace ||
            (c >= itp_pkg::ChrTab && c <= itp_pkg::ChrCr)) begin
          r.st = SC_LEAD;
        end else if (c == itp_pkg::ChrPlus) begin
          r.st = SC_NUM;
        end else if (c == itp_pkg::ChrMinus) begin
          r.st  = SC_NUM;
          r.neg = 1'b1;
        end else if (dig) begin
          r.st  = SC_NUM;
          r.acc = v[6:0];
        end else begin
          r.st = SC_STOP;
        end
      end
      SC_NUM: begin
        if (dig) begin
          r.acc = v[6:0];
        end else begin
          r.st = SC_STOP;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // Parse state.
  logic [4:0]       pos_q, pos_d;
  itp_pkg::phase_e  phase_q, phase_d;
  logic [13:0]      year_q, year_d;
  logic [6:0]       month_q, month_d, day_q, day_d;
  logic [6:0]       hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic [19:0]      frac_q, frac_d;
  logic [2:0]       fcnt_q, fcnt_d;
  logic             date_ok_q, date_ok_d, failed_q, failed_d;
  logic [2:0]       zidx_q, zidx_d;
  logic             colon_q, colon_d;
  scan_t            hscan_q, hscan_d, mscan_q, mscan_d;

  logic [7:0] c;
  logic       dig;
  logic [3:0] dv;
  logic       zone_do;
  logic [4:0] tpos;

  assign c   = character_i;
  assign dig = (c >= itp_pkg::ChrZero) && (c <= itp_pkg::ChrNine);
  assign dv  = c[3:0];
  assign tpos = pos_q - 5'd10;

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    frac_d    = frac_q;
    fcnt_d    = fcnt_q;
    date_ok_d = date_ok_q;
    failed_d  = failed_q;
    zidx_d    = zidx_q;
    colon_d   = colon_q;
    hscan_d   = hscan_q;
    mscan_d   = mscan_q;
    zone_do   = 1'b0;
    if (cmd_i.clear) begin
      pos_d     = '0;
      phase_d   = itp_pkg::PH_PREFIX;
      year_d    = '0;
      month_d   = '0;
      day_d     = '0;
      hour_d    = '0;
      minute_d  = '0;
      second_d  = '0;
      frac_d    = '0;
      fcnt_d    = '0;
      date_ok_d = 1'b1;
      failed_d  = 1'b0;
      zidx_d    = '0;
      colon_d   = 1'b0;
      hscan_d   = '{st: SC_LEAD, acc: 7'd0, neg: 1'b0};
      mscan_d   = '{st: SC_LEAD, acc: 7'd0, neg: 1'b0};
    end else if (cmd_i.step) begin
      unique case (phase_q)
        itp_pkg::PH_PREFIX: begin
          if (pos_q < 5'd10) begin
            if (itp_pkg::DateShape[pos_q[3:0]]) begin
              if (!dig) date_ok_d = 1'b0;
            end else if (dig || c == itp_pkg::ChrNul) begin
              date_ok_d = 1'b0;
            end
            if (dig) begin
              if (pos_q < 5'd4) begin
                year_d = 14'(year_q * 14'd10 + 14'(dv));
              end else if (pos_q == 5'd5 || pos_q == 5'd6) begin
                month_d = 7'(month_q * 7'd10 + 7'(dv));
              end else if (pos_q == 5'd8 || pos_q == 5'd9) begin
                day_d = 7'(day_q * 7'd10 + 7'(dv));
              end
            end
          end else if (pos_q < 5'd19) begin
            if (itp_pkg::TimeShape[tpos[3:0]]) begin
              if (!dig) failed_d = 1'b1;
            end else if (dig || c == itp_pkg::ChrNul) begin
              failed_d = 1'b1;
            end
            if (dig) begin
              if (pos_q == 5'd11 || pos_q == 5'd12) begin
                hour_d = 7'(hour_q * 7'd10 + 7'(dv));
              end else if (pos_q == 5'd14 || pos_q == 5'd15) begin
                minute_d = 7'(minute_q * 7'd10 + 7'(dv));
              end else if (pos_q == 5'd17 || pos_q == 5'd18) begin
                second_d = 7'(second_q * 7'd10 + 7'(dv));
              end
            end
          end else if (c == itp_pkg::ChrDot) begin
            phase_d = itp_pkg::PH_FRAC;
          end else begin
            phase_d = itp_pkg::PH_ZONE;
            zone_do = 1'b1;
          end
        end
        itp_pkg::PH_FRAC: begin
          if (dig) begin
            if (fcnt_q < 3'd6) begin
              frac_d = 20'(frac_q * 20'd10 + 20'(dv));
              fcnt_d = fcnt_q + 3'd1;
            end
          end else if (c == itp_pkg::ChrPlus || c == itp_pkg::ChrMinus ||
                       c == itp_pkg::ChrNul) begin
            if (fcnt_q == 3'd0) begin
              failed_d = 1'b1;
            end else begin
              phase_d = itp_pkg::PH_ZONE;
              zone_do = 1'b1;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
        default: zone_do = 1'b1;
      endcase
      if (zone_do) begin
        hscan_d = scan_num(hscan_q, c);
        if (zidx_q == 3'd3 && c == itp_pkg::ChrColon) colon_d = 1'b1;
        if (zidx_q >= 3'd4 && colon_q) mscan_d = scan_num(mscan_q, c);
        if (zidx_q < 3'd7) zidx_d = zidx_q + 3'd1;
      end
      if (pos_q < 5'd31) pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= itp_pkg::PH_PREFIX;
      year_q    <= '0;
      month_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      minute_q  <= '0;
      second_q  <= '0;
      frac_q    <= '0;
      fcnt_q    <= '0;
      date_ok_q <= 1'b1;
      failed_q  <= 1'b0;
      zidx_q    <= '0;
      colon_q   <= 1'b0;
      hscan_q   <= '{st: SC_LEAD, acc: 7'd0, neg: 1'b0};
      mscan_q   <= '{st: SC_LEAD, acc: 7'd0, neg: 1'b0};
    end else begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      year_q    <= year_d;
      month_q   <= month_d;
      day_q     <= day_d;
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      second_q  <= second_d;
      frac_q    <= frac_d;
      fcnt_q    <= fcnt_d;
      date_ok_q <= date_ok_d;
      failed_q  <= failed_d;
      zidx_q    <= zidx_d;
      colon_q   <= colon_d;
      hscan_q   <= hscan_d;
      mscan_q   <= mscan_d;
    end
  end

  // Arithmetic pipeline. It runs freely; the controller waits for it to
  // settle after the final character before loading the result.
  logic               s1_ok_q, s1_dok_q, s1_zneg_q;
  logic signed [14:0] s1_ym_q;
  logic [6:0]         s1_mp_q, s1_day_q;
  logic [18:0]        s1_hms_q;
  logic [19:0]        s1_frac_q;
  logic signed [13:0] s1_zmin_q;

  logic               s2_ok_q, s2_dok_q, s2_zneg_q;
  logic signed [14:0] s2_ym_q;
  logic signed [5:0]  s2_era_q;
  logic [13:0]        s2_t_q;
  logic [6:0]         s2_day_q;
  logic [18:0]        s2_hms_q;
  logic [19:0]        s2_frac_q;
  logic signed [40:0] s2_zoff_q;

  logic               s3_ok_q, s3_dok_q;
  logic [8:0]         s3_yoe_q;
  logic signed [12:0] s3_doy_q;
  logic signed [5:0]  s3_era_q;
  logic [18:0]        s3_hms_q;
  logic [19:0]        s3_frac_q;
  logic signed [40:0] s3_zoff_q;

  logic               s4_ok_q, s4_dok_q;
  logic signed [19:0] s4_doe_q;
  logic signed [23:0] s4_era146_q;
  logic [18:0]        s4_hms_q;
  logic [19:0]        s4_frac_q;
  logic signed [40:0] s4_zoff_q;

  logic               s5_ok_q;
  logic signed [23:0] s5_days_q;
  logic [18:0]        s5_hms_q;
  logic [19:0]        s5_frac_q;
  logic signed [40:0] s5_zoff_q;

  logic               s6_ok_q;
  logic signed [41:0] s6_secs_q;
  logic [19:0]        s6_frac_q;
  logic signed [40:0] s6_zoff_q;

  logic               s7_ok_q;
  logic signed [41:0] s7_phi_q;
  logic [39:0]        s7_plo_q;
  logic [19:0]        s7_frac_q;
  logic signed [40:0] s7_zoff_q;

  logic               s8_ok_q;
  logic [58:0]        s8_v_q;

  logic               res_valid_q;
  logic [58:0]        res_epoch_q;

  // Stage 1 terms.
  logic        m_le2;
  logic [36:0] frac_prod;
  logic [13:0] zh60;
  logic        ok_w;
  // Stage 2 terms.
  logic [20:0] era_prod;
  logic signed [40:0] zmin_x;
  // Stage 3 terms.
  logic signed [15:0] era400, yoe_w;
  logic [27:0]        t_prod;
  // Stage 4 terms.
  logic [17:0] y365;
  logic [13:0] c100_prod;
  // Stage 8 terms.
  logic signed [63:0] v_w;

  assign m_le2     = (month_q <= 7'd2);
  assign frac_prod = 37'(frac_q) * 37'(itp_pkg::frac_scale(fcnt_q));
  assign zh60      = 14'(hscan_q.acc) * 14'd60;
  assign ok_w      = !failed_q && (pos_q >= 5'd19) &&
                     !(phase_q == itp_pkg::PH_FRAC && fcnt_q == 3'd0);
  // Year over 400 as (year >> 4) * 1311 >> 15.
  assign era_prod  = 21'(s1_ym_q[13:4]) * 21'd1311;
  assign zmin_x    = 41'(s1_zmin_q);
  assign era400    = 16'(s2_era_q) * 16'sd400;
  assign yoe_w     = 16'(s2_ym_q) - era400;
  // Division by five as a multiply by 13108 and a shift of 16.
  assign t_prod    = 28'(s2_t_q) * 28'd13108;
  assign y365      = 18'(s3_yoe_q) * 18'd365;
  // Division by 100 as a multiply by 41 and a shift of 12.
  assign c100_prod = 14'(s3_yoe_q) * 14'd41;
  assign v_w       = (64'(s7_phi_q) <<< 20) + $signed(64'(s7_plo_q)) +
                     $signed(64'(s7_frac_q)) + 64'(s7_zoff_q);

  always_ff @(posedge clk_i) begin
    s1_ok_q   <= ok_w;
    s1_dok_q  <= date_ok_q;
    s1_zneg_q <= hscan_q.neg;
    s1_ym_q   <= $signed({1'b0, year_q}) - (m_le2 ? 15'sd1 : 15'sd0);
    s1_mp_q   <= m_le2 ? 7'(month_q + 7'd9) : 7'(month_q - 7'd3);
    s1_day_q  <= day_q;
    s1_hms_q  <= 19'(19'(hour_q) * 19'd3600 + 19'(minute_q) * 19'd60 +
                     19'(second_q));
    s1_frac_q <= frac_prod[19:0];
    s1_zmin_q <= mscan_q.neg ? $signed(zh60 - 14'(mscan_q.acc))
                             : $signed(zh60 + 14'(mscan_q.acc));

    s2_ok_q   <= s1_ok_q;
    s2_dok_q  <= s1_dok_q;
    s2_zneg_q <= s1_zneg_q;
    s2_ym_q   <= s1_ym_q;
    s2_era_q  <= s1_ym_q[14] ? -6'sd1 : $signed(era_prod[20:15]);
    s2_t_q    <= 14'(14'(s1_mp_q) * 14'd153 + 14'd2);
    s2_day_q  <= s1_day_q;
    s2_hms_q  <= s1_hms_q;
    s2_frac_q <= s1_frac_q;
    s2_zoff_q <= zmin_x * 41'sd60000000;

    s3_ok_q   <= s2_ok_q;
    s3_dok_q  <= s2_dok_q;
    s3_yoe_q  <= yoe_w[8:0];
    s3_doy_q  <= $signed({1'b0, t_prod[27:16]}) + $signed({6'b0, s2_day_q}) -
                 13'sd1;
    s3_era_q  <= s2_era_q;
    s3_hms_q  <= s2_hms_q;
    s3_frac_q <= s2_frac_q;
    // A plus sign subtracts the zone offset, a minus sign adds it.
    s3_zoff_q <= s2_zneg_q ? s2_zoff_q : -s2_zoff_q;

    s4_ok_q     <= s3_ok_q;
    s4_dok_q    <= s3_dok_q;
    s4_doe_q    <= $signed({2'b0, y365}) + $signed(20'(s3_yoe_q[8:2])) -
                   $signed(20'(c100_prod[13:12])) + 20'(s3_doy_q);
    s4_era146_q <= 24'(s3_era_q) * 24'sd146097;
    s4_hms_q    <= s3_hms_q;
    s4_frac_q   <= s3_frac_q;
    s4_zoff_q   <= s3_zoff_q;

    s5_ok_q   <= s4_ok_q;
    s5_days_q <= s4_dok_q ? (s4_era146_q + 24'(s4_doe_q) - 24'sd719468) : 24'sd0;
    s5_hms_q  <= s4_hms_q;
    s5_frac_q <= s4_frac_q;
    s5_zoff_q <= s4_zoff_q;

    s6_ok_q   <= s5_ok_q;
    s6_secs_q <= 42'(s5_days_q) * 42'sd86400 + $signed(42'(s5_hms_q));
    s6_frac_q <= s5_frac_q;
    s6_zoff_q <= s5_zoff_q;

    // Seconds to microseconds in two parts: the upper 22 bits and the lower 20 bits.
    s7_ok_q   <= s6_ok_q;
    s7_phi_q  <= 42'($signed(s6_secs_q[41:20])) * 42'sd1000000;
    s7_plo_q  <= 40'(s6_secs_q[19:0]) * 40'd1000000;
    s7_frac_q <= s6_frac_q;
    s7_zoff_q <= s6_zoff_q;

    s8_ok_q <= s7_ok_q;
    s8_v_q  <= s7_ok_q ? v_w[58:0] : 59'd0;

    if (cmd_i.load) begin
      res_valid_q <= s8_ok_q;
      res_epoch_q <= s8_v_q;
    end
  end

  assign valid_res_o    = res_valid_q;
  assign epoch_micros_o = res_epoch_q;

endmodule

/* rtl/core/iso_timestamp_text_parser.sv */
// Top level of the ISO timestamp text parser: joins controller and datapath.
// Depends on itp_pkg, itp_ctrl and itp_dpath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | character_i, last_char_i
//   out     | output    | out_valid_o / out_ready_i | valid_res_o, epoch_micros_o
//
// A character is taken on every transfer while the controller is idle. After
// a transfer marked as the last character, intake stops while the epoch
// arithmetic pipeline settles; then the result is loaded into the output
// register. The output register lets characters of the next string be taken
// while a result waits. Reset is asynchronous and active low; it returns the
// parser to the start of a string. A stalled output holds the controller
// until the register is free.
module iso_timestamp_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic signed [58:0] epoch_micros_o
);

  // Commands that steer the datapath: take a character, clear the parse
  // state, and load the output register once the arithmetic has settled.
  itp_pkg::cmd_t cmd;
  logic [58:0]   epoch_w;

  itp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_char_i (last_char_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the field accumulators, the zone scanners, the
  // days-from-civil and microsecond pipeline, and the output register.
  itp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .character_i    (character_i),
    .valid_res_o    (valid_res_o),
    .epoch_micros_o (epoch_w)
  );

  assign epoch_micros_o = $signed(epoch_w);

`ifndef SYNTHESIS
  // A string that failed to parse reports a zero value.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> epoch_micros_o == 59'sd0)
    else $error("invalid result with non-zero value");

  // The final character stops intake until the result is loaded.
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_char_i |=> !in_ready_o)
    else $error("intake continued after final character");

  // A new result only appears while intake is held.
  a_load_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result loaded while characters were being taken");
`endif

endmodule
